FILE: design/fe62_pkg.sv
// Shared constants, register codes and the arctangent table for the Fisheye62 projector.
package fe62_pkg;

	localparam int ANGLE_ITERATIONS_DEF = 24;
	localparam int ATAN_ENTRIES = 32;

	localparam int CFG_REGS = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_MIDDLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_LAST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL     = 3'd5;

	localparam logic [CFG_DATA_W-1:0] FOCAL_RESET = 64'h0001_0000_0001_0000;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

	localparam logic signed [31:0] PIX_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] PIX_MIN = 32'sh8000_0000;

	// atan(2^-i) in Q2.30, truncated
	localparam logic [31:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
		32'h00000000, 32'h00000000
	};

endpackage

FILE: design/fe62_point_if.sv
// Input point channel: valid/ready handshake with a view-plane point.
interface fe62_point_if;
	logic valid;
	logic ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	modport source(output valid, point_x, point_y, input ready);
	modport sink(input valid, point_x, point_y, output ready);
endinterface

FILE: design/fe62_pixel_if.sv
// Output pixel channel: valid/ready handshake with a projected pixel.
interface fe62_pixel_if;
	logic valid;
	logic ready;
	logic signed [31:0] pixel_x;
	logic signed [31:0] pixel_y;
	logic clipped;
	modport source(output valid, pixel_x, pixel_y, clipped, input ready);
	modport sink(input valid, pixel_x, pixel_y, clipped, output ready);
endinterface

FILE: design/fe62_isqrt.sv
// Pipelined floor square root of a 64-bit value, one result bit per stage.
module fe62_isqrt
	import fe62_pkg::*;
#(
	parameter int SB_W = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [63:0]     in_val,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_vld,
	output logic [31:0]     out_root,
	output logic [SB_W-1:0] out_sb
);
	localparam int STEPS = 32;

	logic            vld_s  [0:STEPS-1];
	logic [63:0]     val_s  [0:STEPS-1];
	logic [33:0]     rem_s  [0:STEPS-1];
	logic [31:0]     root_s [0:STEPS-1];
	logic [SB_W-1:0] sb_s   [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic            vld_i;
		logic [63:0]     val_i;
		logic [33:0]     rem_i;
		logic [31:0]     root_i;
		logic [SB_W-1:0] sb_i;
		logic [35:0]     cur;
		logic [35:0]     trial;

		if (k == 0) begin : g_first
			assign vld_i  = in_vld;
			assign val_i  = in_val;
			assign rem_i  = '0;
			assign root_i = '0;
			assign sb_i   = in_sb;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign val_i  = val_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign sb_i   = sb_s[k-1];
		end

		// bring down the next two radicand bits and try 4*root+1
		assign cur   = {rem_i, val_i[63-2*k -: 2]};
		assign trial = {2'b00, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k] <= val_i;
				sb_s[k]  <= sb_i;
				if (cur >= trial) begin
					rem_s[k]  <= 34'(cur - trial);
					root_s[k] <= {root_i[30:0], 1'b1};
				end else begin
					rem_s[k]  <= cur[33:0];
					root_s[k] <= {root_i[30:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[STEPS-1];
	assign out_root = root_s[STEPS-1];
	assign out_sb   = sb_s[STEPS-1];

endmodule

FILE: design/fe62_div.sv
// Pipelined restoring divider: two 62-bit dividends over one shared divisor, 31 quotient bits.
module fe62_div
	import fe62_pkg::*;
#(
	parameter int SB_W = 34
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [61:0]     in_nx,
	input  logic [61:0]     in_ny,
	input  logic [31:0]     in_d,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_vld,
	output logic [30:0]     out_qx,
	output logic [30:0]     out_qy,
	output logic [SB_W-1:0] out_sb
);
	localparam int STEPS = 31;

	logic            vld_s [0:STEPS-1];
	logic [30:0]     lx_s  [0:STEPS-1];
	logic [30:0]     ly_s  [0:STEPS-1];
	logic [31:0]     rx_s  [0:STEPS-1];
	logic [31:0]     ry_s  [0:STEPS-1];
	logic [30:0]     qx_s  [0:STEPS-1];
	logic [30:0]     qy_s  [0:STEPS-1];
	logic [31:0]     d_s   [0:STEPS-1];
	logic [SB_W-1:0] sb_s  [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic            vld_i;
		logic [30:0]     lx_i, ly_i, qx_i, qy_i;
		logic [31:0]     rx_i, ry_i, d_i;
		logic [SB_W-1:0] sb_i;
		logic [32:0]     cx, cy, dd;

		if (k == 0) begin : g_first
			// the quotient fits 31 bits, so the top half is already below the divisor
			assign vld_i = in_vld;
			assign lx_i  = in_nx[30:0];
			assign ly_i  = in_ny[30:0];
			assign rx_i  = {1'b0, in_nx[61:31]};
			assign ry_i  = {1'b0, in_ny[61:31]};
			assign qx_i  = '0;
			assign qy_i  = '0;
			assign d_i   = in_d;
			assign sb_i  = in_sb;
		end else begin : g_next
			assign vld_i = vld_s[k-1];
			assign lx_i  = lx_s[k-1];
			assign ly_i  = ly_s[k-1];
			assign rx_i  = rx_s[k-1];
			assign ry_i  = ry_s[k-1];
			assign qx_i  = qx_s[k-1];
			assign qy_i  = qy_s[k-1];
			assign d_i   = d_s[k-1];
			assign sb_i  = sb_s[k-1];
		end

		assign cx = {rx_i, lx_i[30-k]};
		assign cy = {ry_i, ly_i[30-k]};
		assign dd = {1'b0, d_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lx_s[k] <= lx_i;
				ly_s[k] <= ly_i;
				d_s[k]  <= d_i;
				sb_s[k] <= sb_i;
				if (cx >= dd) begin
					rx_s[k] <= 32'(cx - dd);
					qx_s[k] <= {qx_i[29:0], 1'b1};
				end else begin
					rx_s[k] <= cx[31:0];
					qx_s[k] <= {qx_i[29:0], 1'b0};
				end
				if (cy >= dd) begin
					ry_s[k] <= 32'(cy - dd);
					qy_s[k] <= {qy_i[29:0], 1'b1};
				end else begin
					ry_s[k] <= cy[31:0];
					qy_s[k] <= {qy_i[29:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[STEPS-1];
	assign out_qx  = qx_s[STEPS-1];
	assign out_qy  = qy_s[STEPS-1];
	assign out_sb  = sb_s[STEPS-1];

endmodule

FILE: design/fisheye62_point_projection.sv
// Fisheye62 projection of view-plane points to saturated Q16.16 pixel coordinates.
// Pipeline: 32 square-root stages, one CORDIC stage per angle iteration (capped at the
//   arctangent table size) and 31 divider stages.
// Throughput: one point per cycle; a stalled output holds every stage in place.
// Reset clears all stage valid bits and returns the registers to their defaults
//   (unit focal lengths, everything else zero).
module fisheye62_point_projection
	import fe62_pkg::*;
#(
	parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fe62_point_if.sink            point,
	fe62_pixel_if.source          pixel
);
	localparam int CORDIC_STEPS = (ANGLE_ITERATIONS < ATAN_ENTRIES) ? ANGLE_ITERATIONS
		: ATAN_ENTRIES;

	// ---------------- configuration ----------------
	logic [CFG_DATA_W-1:0] radial_first_q, radial_middle_q, radial_last_q;
	logic [CFG_DATA_W-1:0] tangential_q, focal_q, principal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radial_first_q  <= '0;
			radial_middle_q <= '0;
			radial_last_q   <= '0;
			tangential_q    <= '0;
			focal_q         <= FOCAL_RESET;
			principal_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIAL_FIRST:  radial_first_q  <= cfg_data;
				REG_RADIAL_MIDDLE: radial_middle_q <= cfg_data;
				REG_RADIAL_LAST:   radial_last_q   <= cfg_data;
				REG_TANGENTIAL:    tangential_q    <= cfg_data;
				REG_FOCAL:         focal_q         <= cfg_data;
				REG_PRINCIPAL:     principal_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [31:0] k_coef [0:5];
	logic signed [31:0] p1, p2;

	assign k_coef[0] = $signed(radial_first_q[63:32]);
	assign k_coef[1] = $signed(radial_first_q[31:0]);
	assign k_coef[2] = $signed(radial_middle_q[63:32]);
	assign k_coef[3] = $signed(radial_middle_q[31:0]);
	assign k_coef[4] = $signed(radial_last_q[63:32]);
	assign k_coef[5] = $signed(radial_last_q[31:0]);
	assign p1 = $signed(tangential_q[63:32]);
	assign p2 = $signed(tangential_q[31:0]);

	// ---------------- global advance ----------------
	logic adv;
	logic v_s10;

	assign adv = !v_s10 || pixel.ready;
	assign point.ready = adv;

	// ---------------- squares and sum ----------------
	logic               v_s1, v_s2;
	logic signed [31:0] x_s1, y_s1;
	logic [63:0]        ax2_s1, ay2_s1, sum_s2;
	logic [31:0]        ax_in, ay_in;
	logic [63:0]        sum_in;

	assign ax_in = 32'(point.point_x[31] ? -point.point_x : point.point_x);
	assign ay_in = 32'(point.point_y[31] ? -point.point_y : point.point_y);
	assign sum_in = ax2_s1 + ay2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= point.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= point.point_x;
			y_s1   <= point.point_y;
			ax2_s1 <= ax_in * ax_in;
			ay2_s1 <= ay_in * ay_in;
			sum_s2 <= sum_in;
		end
	end

	logic signed [31:0] x_s2, y_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
		end
	end

	// ---------------- radius ----------------
	logic        sq_vld;
	logic [31:0] sq_root;
	logic [63:0] sq_sb;

	fe62_isqrt #(.SB_W(64)) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (v_s2),
		.in_val  (sum_s2),
		.in_sb   ({x_s2, y_s2}),
		.out_vld (sq_vld),
		.out_root(sq_root),
		.out_sb  (sq_sb)
	);

	// ---------------- CORDIC vectoring for atan(r) ----------------
	logic               cv_s [0:CORDIC_STEPS-1];
	logic signed [51:0] cxv_s [0:CORDIC_STEPS-1];
	logic signed [51:0] cyv_s [0:CORDIC_STEPS-1];
	logic signed [33:0] cz_s [0:CORDIC_STEPS-1];
	logic [31:0]        cr_s [0:CORDIC_STEPS-1];
	logic [63:0]        cpt_s [0:CORDIC_STEPS-1];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic               v_i;
		logic signed [51:0] xv_i, yv_i, dx, dy;
		logic signed [33:0] z_i, ang;
		logic [31:0]        r_i;
		logic [63:0]        pt_i;

		if (i == 0) begin : g_first
			assign v_i  = sq_vld;
			assign xv_i = 52'sd1 <<< 40;
			assign yv_i = $signed({4'b0000, sq_root, 16'h0000});
			assign z_i  = '0;
			assign r_i  = sq_root;
			assign pt_i = sq_sb;
		end else begin : g_next
			assign v_i  = cv_s[i-1];
			assign xv_i = cxv_s[i-1];
			assign yv_i = cyv_s[i-1];
			assign z_i  = cz_s[i-1];
			assign r_i  = cr_s[i-1];
			assign pt_i = cpt_s[i-1];
		end

		assign dx  = yv_i >>> i;
		assign dy  = xv_i >>> i;
		assign ang = $signed({2'b00, ATAN_TAB[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i] <= 1'b0;
			end else if (adv) begin
				cv_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cr_s[i]  <= r_i;
				cpt_s[i] <= pt_i;
				if (!yv_i[51]) begin
					cxv_s[i] <= xv_i + dx;
					cyv_s[i] <= yv_i - dy;
					cz_s[i]  <= z_i + ang;
				end else begin
					cxv_s[i] <= xv_i - dx;
					cyv_s[i] <= yv_i + dy;
					cz_s[i]  <= z_i - ang;
				end
			end
		end
	end

	// ---------------- clamp theta ----------------
	logic               v_s3;
	logic [30:0]        theta_s3;
	logic [31:0]        r_s3;
	logic signed [31:0] x_s3, y_s3;
	logic signed [33:0] z_end;
	logic [30:0]        theta_in;

	assign z_end = cz_s[CORDIC_STEPS-1];

	always_comb begin
		priority if (z_end[33]) begin
			theta_in = '0;
		end else if (z_end > $signed({3'b000, HALF_PI_Q30})) begin
			theta_in = HALF_PI_Q30;
		end else begin
			theta_in = z_end[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= cv_s[CORDIC_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			theta_s3 <= theta_in;
			r_s3     <= cr_s[CORDIC_STEPS-1];
			x_s3     <= $signed(cpt_s[CORDIC_STEPS-1][63:32]);
			y_s3     <= $signed(cpt_s[CORDIC_STEPS-1][31:0]);
		end
	end

	// ---------------- scale numerators and theta squared ----------------
	logic        v_s4;
	logic [61:0] nx_s4, ny_s4;
	logic [31:0] t30_s4, r_s4;
	logic        sx_s4, sy_s4, zero_s4;
	logic [31:0] mx3, my3;
	logic [62:0] nx_p, ny_p;
	logic [61:0] tt_p;

	assign mx3  = 32'(x_s3[31] ? -x_s3 : x_s3);
	assign my3  = 32'(y_s3[31] ? -y_s3 : y_s3);
	assign nx_p = mx3 * theta_s3;
	assign ny_p = my3 * theta_s3;
	assign tt_p = theta_s3 * theta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s4   <= nx_p[61:0];
			ny_s4   <= ny_p[61:0];
			t30_s4  <= tt_p[61:30];
			r_s4    <= r_s3;
			sx_s4   <= x_s3[31];
			sy_s4   <= y_s3[31];
			zero_s4 <= (r_s3 == '0);
		end
	end

	// ---------------- divide by r ----------------
	logic        dv_vld;
	logic [30:0] qx, qy;
	logic [34:0] dv_sb;

	fe62_div #(.SB_W(35)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_vld (v_s4),
		.in_nx  (nx_s4),
		.in_ny  (ny_s4),
		.in_d   (r_s4),
		.in_sb  ({zero_s4, sx_s4, sy_s4, t30_s4}),
		.out_vld(dv_vld),
		.out_qx (qx),
		.out_qy (qy),
		.out_sb (dv_sb)
	);

	// ---------------- radial polynomial, Horner in Q.28 ----------------
	localparam int HORNER_STEPS = 6;

	logic               hv_s   [0:HORNER_STEPS-1];
	logic signed [41:0] hacc_s [0:HORNER_STEPS-1];
	logic signed [31:0] hxp_s  [0:HORNER_STEPS-1];
	logic signed [31:0] hyp_s  [0:HORNER_STEPS-1];
	logic [31:0]        ht30_s [0:HORNER_STEPS-1];
	logic               hz_s   [0:HORNER_STEPS-1];

	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
		logic               v_i, z_i;
		logic signed [41:0] acc_i;
		logic signed [31:0] xp_i, yp_i, cj;
		logic [31:0]        t30_i;
		logic signed [66:0] prod;

		if (j == 0) begin : g_first
			logic signed [31:0] qxs, qys;
			assign qxs   = $signed({1'b0, qx});
			assign qys   = $signed({1'b0, qy});
			assign v_i   = dv_vld;
			assign z_i   = dv_sb[34];
			assign acc_i = 42'(k_coef[5]);
			assign xp_i  = dv_sb[33] ? -qxs : qxs;
			assign yp_i  = dv_sb[32] ? -qys : qys;
			assign t30_i = dv_sb[31:0];
		end else begin : g_next
			assign v_i   = hv_s[j-1];
			assign z_i   = hz_s[j-1];
			assign acc_i = hacc_s[j-1];
			assign xp_i  = hxp_s[j-1];
			assign yp_i  = hyp_s[j-1];
			assign t30_i = ht30_s[j-1];
		end

		if (j < HORNER_STEPS - 1) begin : g_coef
			assign cj = k_coef[HORNER_STEPS-2-j];
		end else begin : g_one
			assign cj = ONE_Q28;
		end

		assign prod = acc_i * $signed({1'b0, t30_i[31:8]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[j] <= 1'b0;
			end else if (adv) begin
				hv_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				hacc_s[j] <= 42'(prod >>> 22) + 42'(cj);
				hxp_s[j]  <= xp_i;
				hyp_s[j]  <= yp_i;
				ht30_s[j] <= t30_i;
				hz_s[j]   <= z_i;
			end
		end
	end

	// ---------------- tangential products ----------------
	logic               v_s5, zero_s5;
	logic signed [33:0] xy_s5, xx_s5, yy_s5;
	logic signed [41:0] rt_s5;
	logic signed [31:0] xp_s5, yp_s5;
	logic [31:0]        t30_s5;
	logic signed [63:0] pxy, pxx, pyy;
	logic signed [31:0] xp_h, yp_h;

	assign xp_h = hxp_s[HORNER_STEPS-1];
	assign yp_h = hyp_s[HORNER_STEPS-1];
	assign pxy  = xp_h * yp_h;
	assign pxx  = xp_h * xp_h;
	assign pyy  = yp_h * yp_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= hv_s[HORNER_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xy_s5   <= 34'(pxy >>> 30);
			xx_s5   <= 34'(pxx >>> 30);
			yy_s5   <= 34'(pyy >>> 30);
			rt_s5   <= hacc_s[HORNER_STEPS-1];
			xp_s5   <= xp_h;
			yp_s5   <= yp_h;
			t30_s5  <= ht30_s[HORNER_STEPS-1];
			zero_s5 <= hz_s[HORNER_STEPS-1];
		end
	end

	// ---------------- distortion terms ----------------
	logic               v_s6, zero_s6;
	logic signed [43:0] qx_s6, qy_s6;
	logic signed [41:0] dxa_s6, dxb_s6, dya_s6, dyb_s6;
	logic signed [26:0] a_t;
	logic [35:0]        bx_sum, by_sum;
	logic signed [28:0] bx_t, by_t;
	logic signed [23:0] xp8, yp8;
	logic signed [65:0] pqx, pqy;
	logic signed [63:0] pdxa, pdxb, pdya, pdyb;

	// 2*xy >> 8 is the same as xy >> 7
	assign a_t    = 27'(xy_s5 >>> 7);
	assign bx_sum = 36'(t30_s5) + {1'b0, xx_s5[33:0], 1'b0};
	assign by_sum = 36'(t30_s5) + {1'b0, yy_s5[33:0], 1'b0};
	assign bx_t   = $signed({1'b0, bx_sum[35:8]});
	assign by_t   = $signed({1'b0, by_sum[35:8]});
	assign xp8    = 24'(xp_s5 >>> 8);
	assign yp8    = 24'(yp_s5 >>> 8);
	assign pqx    = xp8 * rt_s5;
	assign pqy    = yp8 * rt_s5;
	assign pdxa   = p1 * a_t;
	assign pdxb   = p2 * bx_t;
	assign pdya   = p2 * a_t;
	assign pdyb   = p1 * by_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s6   <= 44'(pqx >>> 22);
			qy_s6   <= 44'(pqy >>> 22);
			dxa_s6  <= 42'(pdxa >>> 22);
			dxb_s6  <= 42'(pdxb >>> 22);
			dya_s6  <= 42'(pdya >>> 22);
			dyb_s6  <= 42'(pdyb >>> 22);
			zero_s6 <= zero_s5;
		end
	end

	// ---------------- distorted point in Q.28 ----------------
	logic               v_s7;
	logic signed [45:0] mx_s7, my_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s6) begin
				mx_s7 <= '0;
				my_s7 <= '0;
			end else begin
				mx_s7 <= 46'(qx_s6) + 46'(dxa_s6) + 46'(dxb_s6);
				my_s7 <= 46'(qy_s6) + 46'(dya_s6) + 46'(dyb_s6);
			end
		end
	end

	// ---------------- focal scaling, split in 16-bit halves ----------------
	logic               v_s8;
	logic signed [62:0] hx_s8, lx_s8, hy_s8, ly_s8;
	logic signed [62:0] phx, plx, phy, ply;

	assign phx = $signed({1'b0, focal_q[63:48]}) * mx_s7;
	assign plx = $signed({1'b0, focal_q[47:32]}) * mx_s7;
	assign phy = $signed({1'b0, focal_q[31:16]}) * my_s7;
	assign ply = $signed({1'b0, focal_q[15:0]}) * my_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s8 <= phx;
			lx_s8 <= plx;
			hy_s8 <= phy;
			ly_s8 <= ply;
		end
	end

	logic               v_s9;
	logic signed [51:0] fx_s9, fy_s9;
	logic signed [79:0] fullx, fully;

	assign fullx = (80'(hx_s8) <<< 16) + 80'(lx_s8);
	assign fully = (80'(hy_s8) <<< 16) + 80'(ly_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s9 <= 52'(fullx >>> 28);
			fy_s9 <= 52'(fully >>> 28);
		end
	end

	// ---------------- principal point and saturation ----------------
	logic signed [31:0] px_s10, py_s10;
	logic               clip_s10;
	logic signed [53:0] sumx, sumy;
	logic signed [31:0] satx, saty;
	logic               clipx, clipy;

	assign sumx = 54'(fx_s9) + $signed({22'd0, principal_q[63:32]});
	assign sumy = 54'(fy_s9) + $signed({22'd0, principal_q[31:0]});

	always_comb begin
		clipx = 1'b1;
		priority if (sumx > 54'(PIX_MAX)) begin
			satx = PIX_MAX;
		end else if (sumx < 54'(PIX_MIN)) begin
			satx = PIX_MIN;
		end else begin
			satx  = sumx[31:0];
			clipx = 1'b0;
		end
	end

	always_comb begin
		clipy = 1'b1;
		priority if (sumy > 54'(PIX_MAX)) begin
			saty = PIX_MAX;
		end else if (sumy < 54'(PIX_MIN)) begin
			saty = PIX_MIN;
		end else begin
			saty  = sumy[31:0];
			clipy = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s10   <= satx;
			py_s10   <= saty;
			clip_s10 <= clipx | clipy;
		end
	end

	assign pixel.valid   = v_s10;
	assign pixel.pixel_x = px_s10;
	assign pixel.pixel_y = py_s10;
	assign pixel.clipped = clip_s10;

	// ---------------- assertions ----------------
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.clipped |-> (pixel.pixel_x == PIX_MAX || pixel.pixel_x == PIX_MIN
			|| pixel.pixel_y == PIX_MAX || pixel.pixel_y == PIX_MIN))
		else $error("clipped flag without a saturated coordinate");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.valid |-> point.ready)
		else $error("input stalled while output stage is empty");

	a_theta_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> theta_s3 <= HALF_PI_Q30)
		else $error("angle above pi/2 after clamp");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && !pixel.ready |=> pixel.valid && $stable(v_s9) && $stable(v_s3))
		else $error("pipeline moved during output stall");

endmodule
